@@ hdl/bea_pkg.sv @@
// Shared types and constants of the binary entropy accumulator.
// No dependencies; every other file of the block imports this package.
package bea_pkg;

    // Field widths fixed by the interface
    localparam int CLASS_W     = 8;
    localparam int SUM_W       = 32;
    localparam int COUNT_OUT_W = 17;

    // Log2 datapath: Q1.30 mantissa, 16 result bits, one squaring per stage
    localparam int MANT_W     = 31;
    localparam int MANT_MSB   = 30;
    localparam int LOG_FRAC_W = 16;

    // Normalize stage + one stage per log bit + log assembly stage
    localparam int LANE_LAT = LOG_FRAC_W + 2;

    // One entropy term stays below 1.0 in Q16.16 plus truncation slack
    localparam int TERM_W = 18;
    localparam int H_W    = TERM_W + 1;

    localparam logic [SUM_W-1:0] SUM_CEIL = '1;

    // Per-cell control that travels alongside the datapath
    typedef struct packed {
        logic valid;
        logic counted;
        logic last;
    } t_cell_ctl;

endpackage

@@ hdl/bea_sq_stage.sv @@
// One bit of the log2 fraction: square the Q1.30 mantissa and renormalize.
// Depends on bea_pkg.
module bea_sq_stage #(
    parameter int XW = 17,
    parameter int EW = 5
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [bea_pkg::MANT_W-1:0]    i_m,
    input  logic [bea_pkg::LOG_FRAC_W-1:0] i_frac,
    input  logic [XW-1:0]                 i_x,
    input  logic [EW-1:0]                 i_e,
    output logic [bea_pkg::MANT_W-1:0]    o_m,
    output logic [bea_pkg::LOG_FRAC_W-1:0] o_frac,
    output logic [XW-1:0]                 o_x,
    output logic [EW-1:0]                 o_e
);
    import bea_pkg::*;

    logic [2*MANT_W-1:0]   prod;
    logic [MANT_W:0]       sq;
    logic                  bit_one;
    logic [MANT_W-1:0]     n_m;
    logic [LOG_FRAC_W-1:0] n_frac;
    logic [MANT_W-1:0]     r_m;
    logic [LOG_FRAC_W-1:0] r_frac;
    logic [XW-1:0]         r_x;
    logic [EW-1:0]         r_e;

    // Square, keep Q1.30 scaling; a result of 2 or more yields a one bit
    always_comb begin
        prod    = i_m * i_m;
        sq      = prod[2*MANT_W-1:MANT_MSB];
        bit_one = sq[MANT_W];
        n_m     = bit_one ? sq[MANT_W:1] : sq[MANT_W-1:0];
        n_frac  = {i_frac[LOG_FRAC_W-2:0], bit_one};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m    <= n_m;
            r_frac <= n_frac;
            r_x    <= i_x;
            r_e    <= i_e;
        end
    end

    assign o_m    = r_m;
    assign o_frac = r_frac;
    assign o_x    = r_x;
    assign o_e    = r_e;

endmodule

@@ hdl/bea_log2_lane.sv @@
// Pipelined -log2(x / ONE) in Q5.16: normalize, one squaring stage per bit,
// then assemble. Depends on bea_pkg and bea_sq_stage.
module bea_log2_lane #(
    parameter int PROB_FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [PROB_FRAC_BITS:0]     i_x,
    output logic [PROB_FRAC_BITS:0]     o_x,
    output logic [$clog2(PROB_FRAC_BITS+1)+bea_pkg::LOG_FRAC_W-1:0] o_neg_log
);
    import bea_pkg::*;

    localparam int XW = PROB_FRAC_BITS + 1;
    localparam int EW = $clog2(PROB_FRAC_BITS + 1);
    localparam int LW = EW + LOG_FRAC_W;
    localparam int SW = $clog2(MANT_W);

    logic [EW-1:0]         lead;
    logic [SW-1:0]         sh;
    logic [MANT_W-1:0]     n_m0;
    logic [MANT_W-1:0]     r_m0;
    logic [XW-1:0]         r_x0;
    logic [EW-1:0]         r_e0;

    logic [MANT_W-1:0]     m_chain    [0:LOG_FRAC_W];
    logic [LOG_FRAC_W-1:0] frac_chain [0:LOG_FRAC_W];
    logic [XW-1:0]         x_chain    [0:LOG_FRAC_W];
    logic [EW-1:0]         e_chain    [0:LOG_FRAC_W];

    logic [EW-1:0]         int_part;
    logic [LW-1:0]         n_l;
    logic [LW-1:0]         r_l;
    logic [XW-1:0]         r_x_out;

    // Leading-one position and shift into Q1.30
    always_comb begin
        lead = '0;
        for (int i = 0; i < XW; i++) begin
            if (i_x[i]) begin
                lead = EW'(i);
            end
        end
        sh   = SW'(MANT_MSB) - SW'(lead);
        n_m0 = MANT_W'(i_x) << sh;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m0 <= n_m0;
            r_x0 <= i_x;
            r_e0 <= lead;
        end
    end

    assign m_chain[0]    = r_m0;
    assign frac_chain[0] = '0;
    assign x_chain[0]    = r_x0;
    assign e_chain[0]    = r_e0;

    // One fraction bit per stage, MSB first
    for (genvar k = 0; k < LOG_FRAC_W; k++) begin : g_sq
        bea_sq_stage #(
            .XW(XW),
            .EW(EW)
        ) u_sq (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_m   (m_chain[k]),
            .i_frac(frac_chain[k]),
            .i_x   (x_chain[k]),
            .i_e   (e_chain[k]),
            .o_m   (m_chain[k+1]),
            .o_frac(frac_chain[k+1]),
            .o_x   (x_chain[k+1]),
            .o_e   (e_chain[k+1])
        );
    end

    // (PROB_FRAC_BITS - e) * 2^16 - frac
    always_comb begin
        int_part = EW'(PROB_FRAC_BITS) - e_chain[LOG_FRAC_W];
        n_l      = {int_part, {LOG_FRAC_W{1'b0}}} - {{EW{1'b0}}, frac_chain[LOG_FRAC_W]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l     <= n_l;
            r_x_out <= x_chain[LOG_FRAC_W];
        end
    end

    assign o_x       = r_x_out;
    assign o_neg_log = r_l;

endmodule

@@ hdl/bea_accum.sv @@
// Saturating entropy sum and cell tally, with the result register.
// Depends on bea_pkg.
module bea_accum #(
    parameter int MAX_CELLS = 65536
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bea_pkg::t_cell_ctl                i_ctl,
    input  logic [bea_pkg::H_W-1:0]           i_h,
    input  logic                              i_out_stall,
    output logic                              o_en,
    output logic                              o_out_valid,
    output logic [bea_pkg::SUM_W-1:0]         o_region_entropy,
    output logic [bea_pkg::COUNT_OUT_W-1:0]   o_cells_counted,
    output logic                              o_sum_saturated
);
    import bea_pkg::*;

    localparam int CW = $clog2(MAX_CELLS + 1);

    logic [SUM_W-1:0]       r_sum;
    logic [CW-1:0]          r_tally;
    logic                   r_sat;
    logic [SUM_W-1:0]       n_sum;
    logic [CW-1:0]          n_tally;
    logic                   n_sat;
    logic [SUM_W:0]         sum_wide;
    logic [CW-1:0]          tally_inc;
    logic                   step;
    logic                   load;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [SUM_W-1:0]       r_total;
    logic [COUNT_OUT_W-1:0] r_count;
    logic                   r_sat_out;

    // Whole pipeline moves unless a result waits on a stalled receiver
    assign o_en = !(r_out_valid && i_out_stall);
    assign step = i_ctl.valid && o_en;
    assign load = step && i_ctl.last;

    // State after this cell
    always_comb begin
        n_sum     = r_sum;
        n_tally   = r_tally;
        n_sat     = r_sat;
        sum_wide  = {1'b0, r_sum} + (SUM_W+1)'(i_h);
        tally_inc = (r_tally < CW'(MAX_CELLS)) ? r_tally + CW'(1) : r_tally;
        if (i_ctl.counted) begin
            if (sum_wide >= {1'b0, SUM_CEIL}) begin
                n_sum = SUM_CEIL;
                n_sat = 1'b1;
            end else begin
                n_sum = sum_wide[SUM_W-1:0];
            end
            n_tally = tally_inc;
            if (tally_inc >= CW'(MAX_CELLS)) begin
                n_tally = CW'(MAX_CELLS);
                n_sat   = 1'b1;
            end
        end
    end

    // Accumulators clear after the last cell of a region
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_tally <= '0;
            r_sat   <= 1'b0;
        end else if (step) begin
            if (i_ctl.last) begin
                r_sum   <= '0;
                r_tally <= '0;
                r_sat   <= 1'b0;
            end else begin
                r_sum   <= n_sum;
                r_tally <= n_tally;
                r_sat   <= n_sat;
            end
        end
    end

    // Result register
    always_comb begin
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_total   <= n_sum;
            r_count   <= COUNT_OUT_W'(n_tally);
            r_sat_out <= n_sat;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_region_entropy = r_total;
    assign o_cells_counted  = r_count;
    assign o_sum_saturated  = r_sat_out;

endmodule

@@ hdl/binary_entropy_accumulator.sv @@
// Binary entropy accumulator, top level. Uses bea_pkg, bea_log2_lane, bea_accum.
// Throughput: one cell per cycle; the 16-stage log2 squaring chain is fully
// pipelined, and the whole pipeline holds only while a result is stalled.
// Reset (synchronous, active low) clears the sums, the class code and all valid bits.
module binary_entropy_accumulator #(
    parameter int PROB_FRAC_BITS = 16,
    parameter int MAX_CELLS      = 65536
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [bea_pkg::CLASS_W-1:0]       i_cfg_wr_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [PROB_FRAC_BITS:0]           i_likelihood,
    input  logic                              i_likelihood_missing,
    input  logic                              i_inside_map,
    input  logic [bea_pkg::CLASS_W-1:0]       i_cell_class,
    input  logic                              i_last_cell,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [bea_pkg::SUM_W-1:0]         o_region_entropy,
    output logic [bea_pkg::COUNT_OUT_W-1:0]   o_cells_counted,
    output logic                              o_sum_saturated
);
    import bea_pkg::*;

    localparam int XW    = PROB_FRAC_BITS + 1;
    localparam int LW    = $clog2(PROB_FRAC_BITS + 1) + LOG_FRAC_W;
    localparam int CTL_N = LANE_LAT + 2;
    localparam logic [XW-1:0] PROB_ONE = XW'(1) << PROB_FRAC_BITS;

    logic              en;
    logic [CLASS_W-1:0] r_free_code;
    logic [XW-1:0]     n_p;
    logic [XW-1:0]     r_p;
    logic [XW-1:0]     r_q;
    t_cell_ctl         n_in_ctl;
    t_cell_ctl         r_in_ctl;
    t_cell_ctl         r_ctl [0:CTL_N-1];
    logic [XW-1:0]     p_x;
    logic [XW-1:0]     q_x;
    logic [LW-1:0]     p_log;
    logic [LW-1:0]     q_log;
    logic [XW+LW-1:0]  p_prod;
    logic [XW+LW-1:0]  q_prod;
    logic [TERM_W-1:0] r_tp;
    logic [TERM_W-1:0] r_tq;
    logic [H_W-1:0]    r_h;

    assign o_in_stall = !en;

    // Free-space class register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_code <= '0;
        end else if (i_cfg_wr_en) begin
            r_free_code <= i_cfg_wr_data;
        end
    end

    // Missing reads as zero, anything above one is clamped to one
    always_comb begin
        if (i_likelihood_missing) begin
            n_p = '0;
        end else if (i_likelihood > PROB_ONE) begin
            n_p = PROB_ONE;
        end else begin
            n_p = i_likelihood;
        end
        n_in_ctl.valid   = i_in_valid;
        n_in_ctl.counted = i_inside_map && (i_cell_class == r_free_code);
        n_in_ctl.last    = i_last_cell;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl <= '0;
        end else if (en) begin
            r_in_ctl <= n_in_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p <= n_p;
            r_q <= PROB_ONE - n_p;
        end
    end

    // Control shift line alongside the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CTL_N; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (en) begin
            r_ctl[0] <= r_in_ctl;
            for (int k = 1; k < CTL_N; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    // -log2 of p and of 1-p
    bea_log2_lane #(
        .PROB_FRAC_BITS(PROB_FRAC_BITS)
    ) u_lane_p (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_x      (r_p),
        .o_x      (p_x),
        .o_neg_log(p_log)
    );

    bea_log2_lane #(
        .PROB_FRAC_BITS(PROB_FRAC_BITS)
    ) u_lane_q (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_x      (r_q),
        .o_x      (q_x),
        .o_neg_log(q_log)
    );

    // Terms x * -log2(x), a zero x gives a zero term
    assign p_prod = (XW+LW)'(p_x) * (XW+LW)'(p_log);
    assign q_prod = (XW+LW)'(q_x) * (XW+LW)'(q_log);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tp <= TERM_W'(p_prod >> PROB_FRAC_BITS);
            r_tq <= TERM_W'(q_prod >> PROB_FRAC_BITS);
        end
    end

    // Cell entropy
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h <= H_W'(r_tp) + H_W'(r_tq);
        end
    end

    bea_accum #(
        .MAX_CELLS(MAX_CELLS)
    ) u_accum (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (r_ctl[CTL_N-1]),
        .i_h             (r_h),
        .i_out_stall     (i_out_stall),
        .o_en            (en),
        .o_out_valid     (o_out_valid),
        .o_region_entropy(o_region_entropy),
        .o_cells_counted (o_cells_counted),
        .o_sum_saturated (o_sum_saturated)
    );

endmodule

@@ bench/bea_checker.sv @@
// Checker for the binary entropy accumulator: watches the configuration port and both
// channels, predicts each region total and compares it field by field.
// Depends on bea_pkg for the field widths; instantiated beside the block by testbench.
module bea_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [bea_pkg::CLASS_W-1:0]     i_cfg_wr_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [16:0]                     i_likelihood,
    input  logic                            i_likelihood_missing,
    input  logic                            i_inside_map,
    input  logic [bea_pkg::CLASS_W-1:0]     i_cell_class,
    input  logic                            i_last_cell,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [bea_pkg::SUM_W-1:0]       i_region_entropy,
    input  logic [bea_pkg::COUNT_OUT_W-1:0] i_cells_counted,
    input  logic                            i_sum_saturated,
    input  logic                            i_end_of_test,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int              PROB_BITS = 16;
    localparam longint unsigned PROB_ONE  = 64'd1 << PROB_BITS;
    localparam longint unsigned CELL_CAP  = 64'd65536;
    localparam longint unsigned SUM_TOP   = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [bea_pkg::SUM_W-1:0]       total;
        logic [bea_pkg::COUNT_OUT_W-1:0] count;
        logic                            sat;
    } t_region_total;

    t_region_total                region_totals_q[$];
    logic [bea_pkg::CLASS_W-1:0]  free_code = '0;
    longint unsigned              run_sum   = 0;
    longint unsigned              run_cells = 0;
    logic                         run_sat   = 1'b0;
    bit                           end_seen  = 1'b0;
    int                           fail_count = 0;
    int                           pending    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %0s", $realtime, msg);
        fail_count++;
    endtask

    // -log2(x / one) in Q16.16: normalize to Q1.30, then square 16 times, one bit each
    function automatic longint unsigned surprisal_q16(input longint unsigned x);
        int              lead;
        longint unsigned mant;
        longint unsigned frac;
        lead = 0;
        for (int b = 0; b <= PROB_BITS; b++)
            if (x[b]) lead = b;
        mant = x << (30 - lead);
        frac = 0;
        for (int k = 0; k < 16; k++) begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= (64'd1 << 31)) begin
                frac = frac | 64'd1;
                mant = mant >> 1;
            end
        end
        return 64'(PROB_BITS - lead) * 64'd65536 - frac;
    endfunction

    // x * -log2(x), truncated; zero probability contributes nothing
    function automatic longint unsigned plogp_term(input longint unsigned x);
        if (x == 0)
            return 0;
        return (x * surprisal_q16(x)) >> PROB_BITS;
    endfunction

    // Fold one accepted cell into the running region totals
    task automatic take_cell();
        longint unsigned p;
        longint unsigned h;
        t_region_total   res;
        p = i_likelihood_missing ? 64'd0 : 64'(i_likelihood);
        if (p > PROB_ONE)
            p = PROB_ONE;
        if (i_inside_map && i_cell_class == free_code) begin
            h = plogp_term(p) + plogp_term(PROB_ONE - p);
            run_sum = run_sum + h;
            if (run_sum >= SUM_TOP) begin
                run_sum = SUM_TOP;
                run_sat = 1'b1;
            end
            if (run_cells < CELL_CAP)
                run_cells++;
            if (run_cells >= CELL_CAP) begin
                run_cells = CELL_CAP;
                run_sat   = 1'b1;
            end
        end
        if (i_last_cell) begin
            res.total = run_sum[31:0];
            res.count = run_cells[16:0];
            res.sat   = run_sat;
            region_totals_q.push_back(res);
            run_sum   = 0;
            run_cells = 0;
            run_sat   = 1'b0;
        end
    endtask

    task automatic check_result();
        t_region_total want;
        if (region_totals_q.size() == 0) begin
            flag_error($sformatf("unexpected result: total %0d count %0d sat %0b",
                                 i_region_entropy, i_cells_counted, i_sum_saturated));
        end else begin
            want = region_totals_q.pop_front();
            if (i_region_entropy !== want.total)
                flag_error($sformatf("region_entropy %0d, predicted %0d",
                                     i_region_entropy, want.total));
            if (i_cells_counted !== want.count)
                flag_error($sformatf("cells_counted %0d, predicted %0d",
                                     i_cells_counted, want.count));
            if (i_sum_saturated !== want.sat)
                flag_error($sformatf("sum_saturated %0b, predicted %0b",
                                     i_sum_saturated, want.sat));
        end
    endtask

    // Sample every channel at the edge where its transfer happens
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            free_code = '0;
            run_sum   = 0;
            run_cells = 0;
            run_sat   = 1'b0;
            region_totals_q.delete();
        end else begin
            if (i_cfg_wr_en)
                free_code = i_cfg_wr_data;
            if (i_out_valid && !i_out_stall)
                check_result();
            if (i_in_valid && !i_in_stall)
                take_cell();
            if (i_end_of_test && !end_seen) begin
                end_seen = 1'b1;
                if (region_totals_q.size() != 0)
                    flag_error($sformatf("%0d predicted results never arrived",
                                         region_totals_q.size()));
            end
        end
        pending = region_totals_q.size();
    end

endmodule

@@ bench/testbench.sv @@
// Top of the bench for binary_entropy_accumulator: clock, reset, cell stimulus,
// result-side stalls and the verdict. Depends on bea_pkg, the block and bea_checker.
module testbench;

    localparam int LIKELY_W     = 17;
    localparam int PROB_ONE     = 65536;
    localparam int PROB_MAX     = (1 << LIKELY_W) - 1;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_CELLS  = 375;
    localparam int BURST_CELLS  = 24;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [bea_pkg::CLASS_W-1:0]     cfg_wr_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [LIKELY_W-1:0]             likelihood;
    logic                            likelihood_missing;
    logic                            inside_map;
    logic [bea_pkg::CLASS_W-1:0]     cell_class;
    logic                            last_cell;
    logic                            out_valid;
    logic                            out_stall;
    logic [bea_pkg::SUM_W-1:0]       region_entropy;
    logic [bea_pkg::COUNT_OUT_W-1:0] cells_counted;
    logic                            sum_saturated;
    logic                            end_of_test;
    int                              fail_count;
    int                              pending;

    bit                              hold_req   = 1'b0;
    bit                              send_quiet = 1'b0;
    int                              sent       = 0;
    logic [bea_pkg::CLASS_W-1:0]     cur_code   = '0;

    binary_entropy_accumulator u_top (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_wr_en          (cfg_wr_en),
        .i_cfg_wr_data        (cfg_wr_data),
        .i_in_valid           (in_valid),
        .o_in_stall           (in_stall),
        .i_likelihood         (likelihood),
        .i_likelihood_missing (likelihood_missing),
        .i_inside_map         (inside_map),
        .i_cell_class         (cell_class),
        .i_last_cell          (last_cell),
        .o_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .o_region_entropy     (region_entropy),
        .o_cells_counted      (cells_counted),
        .o_sum_saturated      (sum_saturated)
    );

    bea_checker u_checker (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_wr_en          (cfg_wr_en),
        .i_cfg_wr_data        (cfg_wr_data),
        .i_in_valid           (in_valid),
        .i_in_stall           (in_stall),
        .i_likelihood         (likelihood),
        .i_likelihood_missing (likelihood_missing),
        .i_inside_map         (inside_map),
        .i_cell_class         (cell_class),
        .i_last_cell          (last_cell),
        .i_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .i_region_entropy     (region_entropy),
        .i_cells_counted      (cells_counted),
        .i_sum_saturated      (sum_saturated),
        .i_end_of_test        (end_of_test),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    // Result side: random stall after each transfer, plus one long hold-off on request
    initial begin
        int left;
        int results;
        bit quiet;
        left    = 0;
        results = 0;
        quiet   = 1'b0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                left     = HOLD_CYCLES;
            end else if (out_valid && !out_stall) begin
                results++;
                if (results % 16 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                left = quiet ? 0 : $urandom_range(0, 16);
            end else if (left > 0) begin
                left--;
            end
            out_stall <= (left > 0);
        end
    end

    // One cell transfer; valid stays high across back-to-back cells
    task automatic send_cell(input logic [LIKELY_W-1:0] p, input logic miss,
                             input logic in_map, input logic [7:0] cls,
                             input logic last, input bit burst);
        int gap;
        sent++;
        if (sent % 64 == 0)
            send_quiet = ($urandom_range(0, 3) == 0);
        gap = (burst || send_quiet) ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid           <= 1'b1;
        likelihood         <= p;
        likelihood_missing <= miss;
        inside_map         <= in_map;
        cell_class         <= cls;
        last_cell          <= last;
        do @(posedge clk); while (in_stall);
    endtask

    // Wait until every predicted result is out and the pipeline has emptied
    task automatic drain_block();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_free_code(input logic [7:0] code);
        drain_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= code;
        cur_code     = code;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly counted cells, probabilities weighted toward the edges of the range
    task automatic send_random_cell();
        logic [LIKELY_W-1:0] p;
        logic [7:0]          cls;
        case ($urandom_range(0, 9))
            0:       p = '0;
            1:       p = LIKELY_W'(PROB_ONE);
            2:       p = LIKELY_W'($urandom_range(PROB_ONE + 1, PROB_MAX));
            3:       p = LIKELY_W'($urandom_range(1, 15));
            4:       p = LIKELY_W'($urandom_range(PROB_ONE - 16, PROB_ONE - 1));
            default: p = LIKELY_W'($urandom_range(0, PROB_ONE));
        endcase
        cls = ($urandom_range(0, 3) != 0) ? cur_code : 8'($urandom_range(0, 255));
        send_cell(p, $urandom_range(0, 9) == 0, $urandom_range(0, 9) != 0, cls,
                  $urandom_range(0, 15) == 0, 1'b0);
    endtask

    // Stimulus and verdict
    initial begin
        logic [7:0] phase_code[4];
        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        in_valid           <= 1'b0;
        likelihood         <= '0;
        likelihood_missing <= 1'b0;
        inside_map         <= 1'b0;
        cell_class         <= '0;
        last_cell          <= 1'b0;
        end_of_test        <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: probability extremes, clamping, missing, outside, class mismatch
        write_free_code(8'h00);
        send_cell(17'd0,      1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
        send_cell(17'd65536,  1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
        send_cell(17'h1FFFF,  1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
        send_cell(17'd65537,  1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
        send_cell(17'd1,      1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
        send_cell(17'd65535,  1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
        send_cell(17'd32768,  1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
        send_cell(17'd32768,  1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
        send_cell(17'd32768,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        send_cell(17'd32768,  1'b0, 1'b1, 8'hFF, 1'b0, 1'b0);
        send_cell(17'd12345,  1'b0, 1'b1, 8'h00, 1'b1, 1'b0);
        // last cells that are not counted, or missing, still close their region
        send_cell(17'd40000,  1'b0, 1'b0, 8'h00, 1'b1, 1'b0);
        send_cell(17'd40000,  1'b0, 1'b1, 8'h7F, 1'b1, 1'b0);
        send_cell(17'h1FFFF,  1'b1, 1'b1, 8'h00, 1'b1, 1'b0);

        write_free_code(8'hFF);
        send_cell(17'd21845,  1'b0, 1'b1, 8'hFF, 1'b0, 1'b0);
        send_cell(17'd21845,  1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
        send_cell(17'd43690,  1'b0, 1'b1, 8'hFF, 1'b1, 1'b0);

        // Back-to-back burst at half probability, one full bit per cell
        write_free_code(8'h5A);
        for (int n = 0; n < BURST_CELLS; n++)
            send_cell(17'd32768, 1'b0, 1'b1, 8'h5A, n == BURST_CELLS - 1, 1'b1);

        // Random regions under several free-space codes
        phase_code[0] = 8'hFF;
        phase_code[1] = 8'h00;
        phase_code[2] = 8'($urandom_range(1, 254));
        phase_code[3] = 8'($urandom_range(0, 255));
        for (int ph = 0; ph < 4; ph++) begin
            write_free_code(phase_code[ph]);
            for (int i = 0; i < PHASE_CELLS; i++) begin
                if (ph == 0 && i == 100)
                    hold_req = 1'b1;
                send_random_cell();
            end
        end

        drain_block();
        end_of_test <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
hdl/bea_pkg.sv
hdl/bea_sq_stage.sv
hdl/bea_log2_lane.sv
hdl/bea_accum.sv
hdl/binary_entropy_accumulator.sv
bench/bea_checker.sv
bench/testbench.sv
